// ===== hdl/multi_voice_pcm_mixer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the PCM mixer
// Shared helpers for concurrent checks, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_PCM_MIXER_UNIT_DEFINES_SVH
`define MULTI_VOICE_PCM_MIXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MVPM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MVPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mvpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvpm_pkg
// Opcodes, fixed widths, limits and arithmetic helpers of the PCM mixer.
// ----------------------------------------------------------------------------
package mvpm_pkg;

    // Opcodes carried in the input tuser.
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Mix accumulator: 17-bit contributions from up to 32 voices.
    localparam int ACC_W = 22;

    localparam logic [16:0] UNITY     = 17'd65536;
    localparam logic [17:0] RATE_MIN  = 18'd2972;
    localparam logic [17:0] RATE_MAX  = 18'd148607;

    typedef logic signed [MUL_P_W-1:0] product_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // Saturate a 17-bit Q1.16 value to unity.
    function automatic logic [16:0] sat_unity(input logic [16:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // Clamp the 24-bit rate into the supported window.
    function automatic logic [17:0] clamp_rate(input logic [23:0] v);
        logic [17:0] r;
        if (v < 24'(RATE_MIN)) begin
            r = RATE_MIN;
        end else if (v > 24'(RATE_MAX)) begin
            r = RATE_MAX;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    // Divide a product by 2^32, truncating toward zero.
    function automatic logic signed [16:0] scale_down(input product_t p);
        product_t q;
        q = p >>> 32;
        if (p[MUL_P_W-1] && (p[31:0] != 32'd0)) begin
            q = q + product_t'(1);
        end
        return q[16:0];
    endfunction

    // Saturate a mix sum to 16 bits.
    function automatic logic signed [15:0] sat16(input acc_t v);
        logic signed [15:0] r;
        if (v < -acc_t'(32768)) begin
            r = 16'sh8000;
        end else if (v > acc_t'(32767)) begin
            r = 16'sh7fff;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/mvpm_sample_mem.sv =====
// ----------------------------------------------------------------------------
// mvpm_sample_mem
// Sample word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvpm_sample_mem #(
    parameter int AW = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem_reg [2**AW];
    logic [15:0] rd_data_reg;

    // Write on load, read every cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mvpm_mul.sv =====
// ----------------------------------------------------------------------------
// mvpm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mvpm_mul
    import mvpm_pkg::*;
(
    input  logic                       aclk,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic signed [MUL_B_W-1:0]  op_b,
    output product_t                   product
);

    product_t product_reg;

    // One product per cycle, registered before any further use.
    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

// ===== hdl/multi_voice_pcm_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer_unit
// Sample store and playback voices mixed into one stereo frame per tick.
// ----------------------------------------------------------------------------
// Channel   Direction  tuser     tdata
// s_axis    in         opcode    voice, address, sample, frames, stereo,
//                                volume, pan, rate, loop (112 bits)
// m_axis    out        -         left, right, started voice, start ok,
//                                op done (40 bits)
//
// Load and unknown opcodes go straight to the result register; stop and
// update pass through the voice operation state. A start scans the slots in
// order and takes the first idle one. A tick visits every voice in turn:
// idle voices are passed over, a voice that ends without looping is stopped,
// and a playing voice is read and mixed through the single sample read port
// and the single shared multiplier (four products per voice).
// Reset is synchronous, active low, and clears all voice flags.
// A result waits in its output register until taken; the next transaction is
// accepted once it has gone. SAMPLE_WORDS must be a power of two; not enforced.
// ----------------------------------------------------------------------------
`include "multi_voice_pcm_mixer_unit_defines.svh"

module multi_voice_pcm_mixer_unit
    import mvpm_pkg::*;
#(
    parameter int VOICES       = 8,
    parameter int SAMPLE_WORDS = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] opcode
    input  logic [2:0]   s_tuser,
    // [2:0] voice, [18:3] address, [34:19] sample_value, [51:35] frame_count,
    // [52] stereo, [69:53] volume, [86:70] pan, [110:87] rate, [111] loop
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] left_out, [31:16] right_out, [34:32] started_voice,
    // [35] start_ok, [36] op_done, [39:37] zero
    output logic [39:0]  m_tdata
);

    localparam int AW = $clog2(SAMPLE_WORDS);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW = $clog2(VOICES + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FIND = 4'd1;
    localparam logic [3:0] ST_VOP  = 4'd2;
    localparam logic [3:0] ST_TCHK = 4'd3;
    localparam logic [3:0] ST_ADV  = 4'd4;
    localparam logic [3:0] ST_RDL  = 4'd5;
    localparam logic [3:0] ST_RDR  = 4'd6;
    localparam logic [3:0] ST_ML2  = 4'd7;
    localparam logic [3:0] ST_MR1  = 4'd8;
    localparam logic [3:0] ST_MR2  = 4'd9;
    localparam logic [3:0] ST_ACR  = 4'd10;
    localparam logic [3:0] ST_WAIT = 4'd11;

    // Input field slices.
    logic [2:0]  in_voice;
    logic [15:0] in_address;
    logic [15:0] in_sample;
    logic [16:0] in_frames;
    logic        in_stereo;
    logic [16:0] in_volume;
    logic [16:0] in_pan;
    logic [23:0] in_rate;
    logic        in_loop;

    assign in_voice   = s_tdata[2:0];
    assign in_address = s_tdata[18:3];
    assign in_sample  = s_tdata[34:19];
    assign in_frames  = s_tdata[51:35];
    assign in_stereo  = s_tdata[52];
    assign in_volume  = s_tdata[69:53];
    assign in_pan     = s_tdata[86:70];
    assign in_rate    = s_tdata[110:87];
    assign in_loop    = s_tdata[111];

    // Control state.
    logic [3:0]        state_reg;
    logic [SW-1:0]     slot_reg;
    logic [2:0]        op_reg;
    logic              hit_reg;
    logic [VOICES-1:0] play_reg;
    logic [VOICES-1:0] loop_reg;
    logic [VOICES-1:0] stereo_reg;
    logic              m_tvalid_reg;

    // Latched transaction fields; frames, volume and pan saturated, rate clamped.
    logic [15:0] addr_in_reg;
    logic [16:0] len_in_reg;
    logic [16:0] gain_in_reg;
    logic [16:0] bal_in_reg;
    logic [17:0] rate_in_reg;
    logic        loop_in_reg;
    logic        stereo_in_reg;

    // Voice records.
    logic [16:0] pos_reg   [VOICES];
    logic [15:0] frac_reg  [VOICES];
    logic [17:0] rate_reg  [VOICES];
    logic [16:0] gain_reg  [VOICES];
    logic [16:0] bal_reg   [VOICES];
    logic [15:0] start_reg [VOICES];
    logic [16:0] len_reg   [VOICES];

    // Datapath registers.
    logic [17:0]        li_reg;
    logic [17:0]        ri_reg;
    logic signed [15:0] sr_reg;
    acc_t               acc_l_reg;
    acc_t               acc_r_reg;

    // Result registers.
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;
    logic [2:0]         started_reg;
    logic               start_ok_reg;
    logic               op_done_reg;

    logic [VW-1:0] si;
    logic          s_accept;
    logic          m_accept;

    assign si       = slot_reg[VW-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid_reg && m_tready;

    // Pointer advance for the current voice.
    logic [18:0] frac_sum;
    logic [17:0] pos_sum;
    logic        at_end;
    logic [16:0] pos_eff;
    logic [17:0] li_calc;

    always_comb begin
        frac_sum = {3'b000, frac_reg[si]} + {1'b0, rate_reg[si]};
        pos_sum  = {1'b0, pos_reg[si]} + 18'(frac_sum[18:16]);
        at_end   = (pos_sum >= {1'b0, len_reg[si]});
        pos_eff  = at_end ? 17'd0 : pos_sum[16:0];
        li_calc  = {2'b00, start_reg[si]}
                 + (stereo_reg[si] ? {pos_eff, 1'b0} : {1'b0, pos_eff});
    end

    // Sample store.
    logic [15:0]   mem_rdata;
    logic [AW-1:0] mem_raddr;

    assign mem_raddr = (state_reg == ST_RDR) ? AW'(ri_reg) : AW'(li_reg);

    mvpm_sample_mem #(
        .AW(AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (s_accept && (s_tuser == OP_LOAD)),
        .wr_addr (AW'(in_address)),
        .wr_data (in_sample),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Operand selection for the shared multiplier.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    product_t                  product;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RDR: begin
                mul_a = MUL_A_W'($signed(mem_rdata));
                mul_b = $signed({1'b0, gain_reg[si]});
            end
            ST_ML2: begin
                mul_a = product[MUL_A_W-1:0];
                mul_b = $signed({1'b0, 17'(UNITY - bal_reg[si])});
            end
            ST_MR1: begin
                mul_a = MUL_A_W'(sr_reg);
                mul_b = $signed({1'b0, gain_reg[si]});
            end
            ST_MR2: begin
                mul_a = product[MUL_A_W-1:0];
                mul_b = $signed({1'b0, bal_reg[si]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mvpm_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    // Sequencer and control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            play_reg     <= '0;
            loop_reg     <= '0;
            stereo_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            op_reg       <= OP_LOAD;
            hit_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        op_reg   <= s_tuser;
                        hit_reg  <= (32'(in_voice) < VOICES);
                        slot_reg <= '0;
                        case (s_tuser)
                            OP_START:  state_reg <= ST_FIND;
                            OP_STOP:   state_reg <= ST_VOP;
                            OP_UPDATE: state_reg <= ST_VOP;
                            OP_TICK:   state_reg <= ST_TCHK;
                            default: begin
                                state_reg    <= ST_WAIT;
                                m_tvalid_reg <= 1'b1;
                            end
                        endcase
                        if ((s_tuser == OP_STOP || s_tuser == OP_UPDATE)
                                && (32'(in_voice) < VOICES)) begin
                            slot_reg <= SW'(in_voice);
                        end
                    end
                end
                ST_FIND: begin
                    if (32'(slot_reg) >= VOICES) begin
                        state_reg    <= ST_WAIT;
                        m_tvalid_reg <= 1'b1;
                    end else if (!play_reg[si]) begin
                        play_reg[si]   <= 1'b1;
                        loop_reg[si]   <= loop_in_reg;
                        stereo_reg[si] <= stereo_in_reg;
                        state_reg      <= ST_WAIT;
                        m_tvalid_reg   <= 1'b1;
                    end else begin
                        slot_reg <= slot_reg + SW'(1);
                    end
                end
                ST_VOP: begin
                    if (hit_reg && play_reg[si] && (op_reg == OP_STOP)) begin
                        play_reg[si] <= 1'b0;
                    end
                    state_reg    <= ST_WAIT;
                    m_tvalid_reg <= 1'b1;
                end
                ST_TCHK: begin
                    if (32'(slot_reg) >= VOICES) begin
                        state_reg    <= ST_WAIT;
                        m_tvalid_reg <= 1'b1;
                    end else if (play_reg[si]) begin
                        state_reg <= ST_ADV;
                    end else begin
                        slot_reg <= slot_reg + SW'(1);
                    end
                end
                ST_ADV: begin
                    if (at_end && !loop_reg[si]) begin
                        play_reg[si] <= 1'b0;
                        slot_reg     <= slot_reg + SW'(1);
                        state_reg    <= ST_TCHK;
                    end else begin
                        state_reg <= ST_RDL;
                    end
                end
                ST_RDL: state_reg <= ST_RDR;
                ST_RDR: state_reg <= ST_ML2;
                ST_ML2: state_reg <= ST_MR1;
                ST_MR1: state_reg <= ST_MR2;
                ST_MR2: state_reg <= ST_ACR;
                ST_ACR: begin
                    slot_reg  <= slot_reg + SW'(1);
                    state_reg <= ST_TCHK;
                end
                ST_WAIT: begin
                    if (m_accept) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Voice records, latched fields and mix datapath.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            addr_in_reg   <= in_address;
            len_in_reg    <= sat_unity(in_frames);
            gain_in_reg   <= sat_unity(in_volume);
            bal_in_reg    <= sat_unity(in_pan);
            rate_in_reg   <= clamp_rate(in_rate);
            loop_in_reg   <= in_loop;
            stereo_in_reg <= in_stereo;
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
        end
        case (state_reg)
            ST_FIND: begin
                if ((32'(slot_reg) < VOICES) && !play_reg[si]) begin
                    pos_reg[si]   <= '0;
                    frac_reg[si]  <= '0;
                    start_reg[si] <= addr_in_reg;
                    len_reg[si]   <= len_in_reg;
                    gain_reg[si]  <= gain_in_reg;
                    bal_reg[si]   <= bal_in_reg;
                    rate_reg[si]  <= rate_in_reg;
                end
            end
            ST_VOP: begin
                if (hit_reg && play_reg[si] && (op_reg == OP_UPDATE)) begin
                    gain_reg[si] <= gain_in_reg;
                    bal_reg[si]  <= bal_in_reg;
                    rate_reg[si] <= rate_in_reg;
                end
            end
            ST_ADV: begin
                pos_reg[si]  <= pos_eff;
                frac_reg[si] <= at_end ? 16'd0 : frac_sum[15:0];
                li_reg       <= li_calc;
                ri_reg       <= li_calc + 18'(stereo_reg[si]);
            end
            ST_ML2: sr_reg <= $signed(mem_rdata);
            ST_MR1: acc_l_reg <= acc_l_reg + ACC_W'(scale_down(product));
            ST_ACR: acc_r_reg <= acc_r_reg + ACC_W'(scale_down(product));
            default: begin
            end
        endcase
    end

    // Result register, loaded as the sequence completes.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            left_reg     <= '0;
            right_reg    <= '0;
            started_reg  <= '0;
            start_ok_reg <= 1'b0;
            op_done_reg  <= 1'b0;
        end
        case (state_reg)
            ST_FIND: begin
                if ((32'(slot_reg) < VOICES) && !play_reg[si]) begin
                    started_reg  <= 3'(slot_reg);
                    start_ok_reg <= 1'b1;
                end
            end
            ST_VOP: op_done_reg <= hit_reg && play_reg[si];
            ST_TCHK: begin
                if (32'(slot_reg) >= VOICES) begin
                    left_reg  <= sat16(acc_l_reg);
                    right_reg <= sat16(acc_r_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, op_done_reg, start_ok_reg, started_reg,
                       right_reg, left_reg};

    // Checks on the sequencer and result register.
    `MVPM_ASSERT_NOW(a_ready_empty, aclk, aresetn, s_tready, !m_tvalid_reg, "ready while result pending")
    `MVPM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready, "ready after accept")
    `MVPM_ASSERT_NOW(a_flags_exclusive, aclk, aresetn, m_tvalid_reg, !(start_ok_reg && op_done_reg), "start and op flags both set")

endmodule
